// ===== rtl/core/ldq_pkg.sv =====
// shared types and constants of the linear array deque
package ldq_pkg;

    // array size and derived widths
    localparam int DEPTH = 64;
    localparam int IW    = $clog2(DEPTH);
    localparam int PW    = IW + 2;
    localparam int VW    = 32;

    // position codes
    localparam logic signed [PW-1:0] POS_NONE = '1;
    localparam logic signed [PW-1:0] POS_ZERO = '0;
    localparam logic signed [PW-1:0] POS_LAST = PW'(DEPTH - 1);

    // operation selected by each incoming word
    typedef enum logic [2:0] {
        MODE_PUSH_REAR  = 3'd0,
        MODE_POP_FRONT  = 3'd1,
        MODE_PUSH_FRONT = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_LIST_FRONT = 3'd4,
        MODE_LIST_REAR  = 3'd5
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    // datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_PUSH_REAR,
        DP_PUSH_FRONT,
        DP_POP_FRONT,
        DP_POP_REAR,
        DP_LIST_FRONT,
        DP_LIST_REAR,
        DP_STEP
    } t_dp_op;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEND
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        t_dp_op  op;
        logic    emit_flag;
        t_status flag_status;
        logic    emit_elem;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic rear_full;
        logic front_zero;
        logic list_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/ldq_if.sv =====
// word channels of the linear array deque
interface ldq_in_if;
    import ldq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [2:0]            mode;
    logic signed [VW-1:0]  push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface ldq_out_if;
    import ldq_pkg::*;

    logic                  valid;
    logic                  ready;
    t_status               status;
    logic signed [VW-1:0]  element_value;
    logic [IW-1:0]         element_index;
    logic                  last_of_run;

    modport source (output valid, output status, output element_value,
                    output element_index, output last_of_run, input ready);
    modport sink   (input valid, input status, input element_value,
                    input element_index, input last_of_run, output ready);
endinterface

// ===== rtl/core/ldq_ctrl.sv =====
// controller state machine of the linear array deque
module ldq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_mode,
    output logic             o_ready,
    input  ldq_pkg::t_dp_stat i_stat,
    output ldq_pkg::t_dp_cmd  o_cmd
);
    import ldq_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    // state and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_PUSH_REAR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    // next state and commands
    always_comb begin
        n_state           = r_state;
        n_mode            = r_mode;
        o_ready           = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.op          = DP_NOP;
        o_cmd.emit_flag   = 1'b0;
        o_cmd.flag_status = ST_OK;
        o_cmd.emit_elem   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_mode        = t_mode'(i_mode);
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_mode) inside
                    MODE_PUSH_REAR: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit_flag = 1'b1;
                            n_state         = S_IDLE;
                            if (i_stat.rear_full) begin
                                o_cmd.flag_status = ST_OVER;
                            end else begin
                                o_cmd.op = DP_PUSH_REAR;
                            end
                        end
                    end
                    MODE_PUSH_FRONT: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit_flag = 1'b1;
                            n_state         = S_IDLE;
                            if (i_stat.front_zero) begin
                                o_cmd.flag_status = ST_OVER;
                            end else begin
                                o_cmd.op = DP_PUSH_FRONT;
                            end
                        end
                    end
                    MODE_POP_FRONT, MODE_POP_REAR, MODE_LIST_FRONT, MODE_LIST_REAR: begin
                        if (i_stat.empty) begin
                            // underflow: one flag result
                            if (i_stat.out_free) begin
                                o_cmd.emit_flag   = 1'b1;
                                o_cmd.flag_status = ST_UNDER;
                                n_state           = S_IDLE;
                            end
                        end else begin
                            // start the first read
                            case (r_mode)
                                MODE_POP_FRONT:  o_cmd.op = DP_POP_FRONT;
                                MODE_POP_REAR:   o_cmd.op = DP_POP_REAR;
                                MODE_LIST_FRONT: o_cmd.op = DP_LIST_FRONT;
                                default:         o_cmd.op = DP_LIST_REAR;
                            endcase
                            n_state = S_SEND;
                        end
                    end
                    default: begin
                        // unused codes give no result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SEND: begin
                // hand out one element, fetch the next while more remain
                if (i_stat.out_free) begin
                    o_cmd.emit_elem = 1'b1;
                    if (i_stat.list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.op = DP_STEP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ldq_dp.sv =====
// datapath of the linear array deque: positions, element memory, result register
module ldq_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ldq_pkg::t_dp_cmd             i_cmd,
    input  logic signed [ldq_pkg::VW-1:0] i_push_value,
    output ldq_pkg::t_dp_stat            o_stat,
    ldq_out_if.source                    o_res
);
    import ldq_pkg::*;

    logic signed [VW-1:0] r_mem [DEPTH];

    logic signed [PW-1:0] r_front, n_front;
    logic signed [PW-1:0] r_rear, n_rear;
    logic signed [VW-1:0] r_value;
    logic signed [VW-1:0] r_rd_data;
    logic [IW-1:0]        r_cursor, n_cursor;
    logic [IW-1:0]        r_count, n_count;
    logic                 r_dir_down, n_dir_down;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic signed [VW-1:0] r_out_value;
    logic [IW-1:0]        r_out_index;
    logic                 r_out_last;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic signed [PW-1:0] rear_inc;
    logic signed [PW-1:0] front_dec;
    logic [IW-1:0]        step_pos;
    logic [IW-1:0]        span;

    assign rear_inc  = r_rear + PW'(1);
    assign front_dec = r_front - PW'(1);
    assign step_pos  = r_dir_down ? (r_cursor - IW'(1)) : (r_cursor + IW'(1));
    assign span      = IW'(r_rear - r_front);

    // status toward the controller
    assign o_stat.empty      = (r_rear == POS_NONE) || (r_front > r_rear);
    assign o_stat.rear_full  = (r_rear >= POS_LAST);
    assign o_stat.front_zero = (r_front == POS_ZERO);
    assign o_stat.list_last  = (r_count == '0);
    assign o_stat.out_free   = !r_out_valid || o_res.ready;

    // position updates and memory addressing
    always_comb begin
        n_front    = r_front;
        n_rear     = r_rear;
        n_cursor   = r_cursor;
        n_count    = r_count;
        n_dir_down = r_dir_down;
        wr_en      = 1'b0;
        wr_addr    = rear_inc[IW-1:0];
        rd_en      = 1'b0;
        rd_addr    = r_front[IW-1:0];
        unique case (i_cmd.op)
            DP_NOP: begin
            end
            DP_PUSH_REAR: begin
                if (r_front == POS_NONE) begin
                    n_front = POS_ZERO;
                end
                n_rear  = rear_inc;
                wr_en   = 1'b1;
                wr_addr = rear_inc[IW-1:0];
            end
            DP_PUSH_FRONT: begin
                wr_en = 1'b1;
                if (r_front == POS_NONE) begin
                    n_front = POS_LAST;
                    n_rear  = POS_LAST;
                    wr_addr = POS_LAST[IW-1:0];
                end else begin
                    n_front = front_dec;
                    wr_addr = front_dec[IW-1:0];
                end
            end
            DP_POP_FRONT: begin
                rd_en    = 1'b1;
                rd_addr  = r_front[IW-1:0];
                n_cursor = r_front[IW-1:0];
                n_count  = '0;
                n_front  = r_front + PW'(1);
            end
            DP_POP_REAR: begin
                rd_en    = 1'b1;
                rd_addr  = r_rear[IW-1:0];
                n_cursor = r_rear[IW-1:0];
                n_count  = '0;
                n_rear   = r_rear - PW'(1);
            end
            DP_LIST_FRONT: begin
                rd_en      = 1'b1;
                rd_addr    = r_front[IW-1:0];
                n_cursor   = r_front[IW-1:0];
                n_count    = span;
                n_dir_down = 1'b0;
            end
            DP_LIST_REAR: begin
                rd_en      = 1'b1;
                rd_addr    = r_rear[IW-1:0];
                n_cursor   = r_rear[IW-1:0];
                n_count    = span;
                n_dir_down = 1'b1;
            end
            DP_STEP: begin
                rd_en    = 1'b1;
                rd_addr  = step_pos;
                n_cursor = step_pos;
                n_count  = r_count - IW'(1);
            end
        endcase
    end

    // element memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= POS_NONE;
            r_rear  <= POS_NONE;
        end else begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    // captured value and walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_push_value;
        end
        r_cursor   <= n_cursor;
        r_count    <= n_count;
        r_dir_down <= n_dir_down;
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_flag || i_cmd.emit_elem) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_flag) begin
            r_out_status <= i_cmd.flag_status;
            r_out_value  <= '0;
            r_out_index  <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_elem) begin
            r_out_status <= ST_OK;
            r_out_value  <= r_rd_data;
            r_out_index  <= r_cursor;
            r_out_last   <= (r_count == '0);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.element_value = r_out_value;
    assign o_res.element_index = r_out_index;
    assign o_res.last_of_run   = r_out_last;

endmodule

// ===== rtl/core/linear_array_deque.sv =====
// top level of the linear array deque
//
//  channel  dir  handshake      payload
//  i_cmd    in   valid / ready  mode, push_value
//  o_res    out  valid / ready  status, element_value, element_index, last_of_run
//
// a push completes in S_EXEC, a pop or list reads there and sends from S_SEND; while o_res
// is ready the single read port of the element memory gives one element a cycle
// a new word is taken only after the previous one has all results in the
// result register; a stalled o_res holds the controller in place
// reset sets front and rear to minus one; the element memory is not cleared
module linear_array_deque (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ldq_in_if.sink    i_cmd,
    ldq_out_if.source o_res
);
    import ldq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cmd_ready;

    assign i_cmd.ready = cmd_ready;

    // controller
    ldq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_mode  (i_cmd.mode),
        .o_ready (cmd_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // datapath
    ldq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_push_value (i_cmd.push_value),
        .o_stat       (dp_stat),
        .o_res        (o_res)
    );

endmodule

// ===== rtl/core/ldq_checker.sv =====
// port checks of the linear array deque and their binding
module ldq_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ldq_in_if.sink    i_cmd,
    ldq_out_if.source o_res
);
    import ldq_pkg::*;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.element_value)
            && $stable(o_res.element_index) && $stable(o_res.last_of_run))
        else $error("stalled result changed");

    // a taken word is not followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command taken while one is in work");

    // flag results carry no element and close the run
    a_flag_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status != ST_OK) |->
            (o_res.element_value == '0) && (o_res.element_index == '0) && o_res.last_of_run)
        else $error("flag result with element data");

    // only listed elements may leave the run open
    a_open_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.last_of_run |-> o_res.status == ST_OK)
        else $error("open run with error status");

endmodule

bind linear_array_deque ldq_checker u_ldq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cmd   (i_cmd),
    .o_res   (o_res)
);

// ===== tb/ldq_checker.sv =====
// checker that predicts and compares the result words of the linear array deque
`timescale 1ns / 100ps
module ldq_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    ldq_in_if    i_cmd,
    ldq_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import ldq_pkg::*;

    // one result word as the deque should send it
    typedef struct {
        t_status              status;
        logic signed [VW-1:0] value;
        logic [IW-1:0]        index;
        logic                 last;
    } t_result_word;

    t_result_word         words_due[$];
    logic signed [VW-1:0] elem_mem [DEPTH];
    int                   front_pos = -1;
    int                   rear_pos  = -1;
    int                   fails     = 0;
    int                   due_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_count;

    task automatic report_mismatch(input string msg);
        $display("ldq_checker: mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic due_word(input t_status st, input logic signed [VW-1:0] v,
                            input int pos, input logic last);
        t_result_word w;
        w.status = st;
        w.value  = v;
        w.index  = IW'(pos);
        w.last   = last;
        words_due.push_back(w);
    endtask

    // apply one command word to the shadow deque and queue its results
    task automatic predict_deque_op(input logic [2:0] mode,
                                    input logic signed [VW-1:0] value);
        int   n;
        int   pos;
        logic empty;
        empty = (rear_pos == -1) || (front_pos > rear_pos);
        case (mode)
            MODE_PUSH_REAR: begin
                if (rear_pos >= DEPTH - 1) begin
                    due_word(ST_OVER, '0, 0, 1'b1);
                end else begin
                    if (front_pos == -1) front_pos = 0;
                    rear_pos++;
                    elem_mem[rear_pos] = value;
                    due_word(ST_OK, '0, 0, 1'b1);
                end
            end
            MODE_PUSH_FRONT: begin
                if (front_pos == 0) begin
                    due_word(ST_OVER, '0, 0, 1'b1);
                end else begin
                    // first push at the front lands on the top cell
                    if (front_pos == -1) begin
                        front_pos = DEPTH - 1;
                        rear_pos  = DEPTH - 1;
                    end else begin
                        front_pos--;
                    end
                    elem_mem[front_pos] = value;
                    due_word(ST_OK, '0, 0, 1'b1);
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (empty) begin
                    due_word(ST_UNDER, '0, 0, 1'b1);
                end else begin
                    pos = (mode == MODE_POP_FRONT) ? front_pos : rear_pos;
                    due_word(ST_OK, elem_mem[pos], pos, 1'b1);
                    if (mode == MODE_POP_FRONT) front_pos++;
                    else rear_pos--;
                end
            end
            MODE_LIST_FRONT, MODE_LIST_REAR: begin
                if (empty) begin
                    due_word(ST_UNDER, '0, 0, 1'b1);
                end else begin
                    n = rear_pos - front_pos + 1;
                    if (n > DEPTH) n = DEPTH;
                    for (int k = 0; k < n; k++) begin
                        pos = (mode == MODE_LIST_FRONT) ? front_pos + k : rear_pos - k;
                        due_word(ST_OK, elem_mem[pos], pos, k == n - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // compare one accepted result word with the oldest one due
    task automatic check_word();
        t_result_word w;
        if (words_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing due, status %0d value %0d",
                                      i_res.status, i_res.element_value));
        end else begin
            w = words_due.pop_front();
            if (i_res.status !== w.status)
                report_mismatch($sformatf("status got %0d expected %0d",
                                          i_res.status, w.status));
            if (i_res.element_value !== w.value)
                report_mismatch($sformatf("element_value got %0d expected %0d",
                                          i_res.element_value, w.value));
            if (i_res.element_index !== w.index)
                report_mismatch($sformatf("element_index got %0d expected %0d",
                                          i_res.element_index, w.index));
            if (i_res.last_of_run !== w.last)
                report_mismatch($sformatf("last_of_run got %0b expected %0b",
                                          i_res.last_of_run, w.last));
        end
    endtask

    // results first: a word leaving at this edge belongs to an earlier command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_pos = -1;
            rear_pos  = -1;
            words_due.delete();
            due_count = 0;
        end else begin
            if (i_res.valid && i_res.ready) check_word();
            if (i_cmd.valid && i_cmd.ready) predict_deque_op(i_cmd.mode, i_cmd.push_value);
            due_count = words_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// top of the deque testbench: clock, reset, stimulus, result sink and verdict
`timescale 1ns / 100ps
module tb_top;
    import ldq_pkg::*;

    localparam int         RAND_WORDS   = 90;
    localparam int         HOLD_CYCLES  = 160;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         TAIL_CYCLES  = 16;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic gaps_on;
    logic hold_go;
    logic res_hold;
    int   words_sent;
    int   word_target;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;

    ldq_in_if  cmd_if ();
    ldq_out_if res_if ();

    linear_array_deque dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    ldq_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // element values: random half the time, else an extreme, all ones or zero
    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(VW-1){1'b1}}};
            1:       return {1'b1, {(VW-1){1'b0}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // offer one command word and wait until it is taken
    task automatic send_word(input logic [2:0] mode, input logic signed [VW-1:0] value);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= mode;
        cmd_if.push_value <= value;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        if (mode <= MODE_LIST_REAR) words_sent++;
    endtask

    task automatic send_run(input logic [2:0] mode, input int count);
        for (int i = 0; i < count; i++) send_word(mode, rand_value());
    endtask

    // stimulus and verdict
    initial begin
        cmd_if.valid      <= 1'b0;
        cmd_if.mode       <= MODE_PUSH_REAR;
        cmd_if.push_value <= '0;
        i_rst_n           <= 1'b0;
        gaps_on    = 1'b0;
        hold_go    = 1'b0;
        words_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty deque right after reset, then the spare codes
        send_word(MODE_POP_FRONT, '0);
        send_word(MODE_POP_REAR, '0);
        send_word(MODE_LIST_FRONT, '0);
        send_word(MODE_LIST_REAR, '0);
        send_word(MODE_SPARE_A, '1);
        send_word(MODE_SPARE_B, '0);

        // first front push sits at the top cell, so the rear is already full
        gaps_on = 1'b1;
        send_word(MODE_PUSH_FRONT, {1'b0, {(VW-1){1'b1}}});
        send_word(MODE_PUSH_REAR, '1);
        send_word(MODE_PUSH_FRONT, {1'b1, {(VW-1){1'b0}}});
        send_word(MODE_PUSH_FRONT, '1);
        send_word(MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        send_word(MODE_LIST_FRONT, '0);
        send_word(MODE_LIST_REAR, '0);

        // drain from both ends until front passes rear
        send_word(MODE_POP_FRONT, '0);
        send_word(MODE_POP_REAR, '0);
        send_word(MODE_POP_FRONT, '0);
        send_word(MODE_POP_FRONT, '0);
        send_word(MODE_POP_REAR, '0);
        send_word(MODE_LIST_REAR, '0);
        send_word(MODE_PUSH_REAR, 32'h5555_5555);
        send_word(MODE_LIST_FRONT, '0);

        // fill from the front into the bottom edge while the sink holds off
        word_target = words_sent + RAND_WORDS;
        hold_go = 1'b1;
        send_run(MODE_PUSH_FRONT, DEPTH + 2);
        send_word(MODE_LIST_FRONT, '0);
        send_word(MODE_LIST_REAR, '0);

        // random runs of pushes and pops with lists and stray codes mixed in
        while (words_sent < word_target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1:    send_run(MODE_PUSH_REAR, $urandom_range(1, 12));
                2, 3:    send_run(MODE_PUSH_FRONT, $urandom_range(1, 12));
                4:       send_run(MODE_POP_FRONT, $urandom_range(1, 6));
                5:       send_run(MODE_POP_REAR, $urandom_range(1, 6));
                6:       send_word(MODE_LIST_FRONT, rand_value());
                7:       send_word(MODE_LIST_REAR, rand_value());
                default: send_word(3'($urandom_range(0, 7)), rand_value());
            endcase
        end
        cmd_if.valid <= 1'b0;

        // drain the outstanding results
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // long hold-off on the result side, counted here
    initial begin
        res_hold = 1'b0;
        wait (hold_go);
        res_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold = 1'b0;
    end

    // result sink with random stalls between words
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, 5) : 0;
            while (stall > 0 || res_hold) begin
                res_if.ready <= 1'b0;
                @(posedge i_clk);
                if (stall > 0) stall--;
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
rtl/core/ldq_pkg.sv
rtl/core/ldq_if.sv
rtl/core/ldq_ctrl.sv
rtl/core/ldq_dp.sv
rtl/core/linear_array_deque.sv
rtl/core/ldq_checker.sv
tb/ldq_checker.sv
tb/tb_top.sv
